[hw/rtl/tpb_pkg.sv]
package tpb_pkg;

    // packer width, must be a power of two
    localparam int WORD_BITS = 32;
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int FILL_W    = WB_LOG;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 24;
    localparam int CNT_W  = LEN_W - 1;
    localparam int OUT_W  = 32;
    localparam int REP_W  = 19;

    localparam logic [BYTE_W-1:0] HDR_LEN_RST = 8'h14;

    localparam int JQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        PH_PULSE,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ONES,
        B_ZEROS,
        B_FLUSH
    } t_bstate;

    typedef struct packed {
        logic [CNT_W-1:0] ones;
        logic [CNT_W-1:0] zeros;
    } t_job;

    typedef struct packed {
        logic [OUT_W-1:0] word;
        logic [REP_W-1:0] rep;
        logic             last;
    } t_result;

endpackage

[hw/rtl/tpb_front.sv]
module tpb_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tpb_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    input  logic [tpb_pkg::BYTE_W-1:0] i_tap_byte,
    input  logic                       i_start_of_file,
    input  logic                       i_jq_full,
    output logic                       o_job_valid,
    output tpb_pkg::t_job              o_job
);
    import tpb_pkg::*;

    logic [BYTE_W-1:0] r_hdr_len, n_hdr_len;
    logic [BYTE_W-1:0] r_hdr_cnt, n_hdr_cnt;
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_long, n_long;

    logic [BYTE_W-1:0] eff_cnt;
    t_phase            eff_phase;
    logic [LEN_W-1:0]  eff_long;
    logic              accept;
    logic              pulse;
    logic [LEN_W-1:0]  pulse_len;
    logic [CNT_W-1:0]  n_bits;
    logic [CNT_W-1:0]  ones;

    assign accept = i_push && !i_jq_full;

    always_comb begin
        eff_cnt   = i_start_of_file ? '0 : r_hdr_cnt;
        eff_phase = i_start_of_file ? PH_PULSE : r_phase;
        eff_long  = i_start_of_file ? '0 : r_long;

        n_hdr_len = i_cfg_we ? i_cfg_wdata : r_hdr_len;
        n_hdr_cnt = r_hdr_cnt;
        n_phase   = r_phase;
        n_long    = r_long;
        pulse     = 1'b0;
        pulse_len = '0;

        if (accept) begin
            n_phase   = eff_phase;
            n_long    = eff_long;
            n_hdr_cnt = eff_cnt;
            if (eff_cnt < r_hdr_len) begin
                n_hdr_cnt = eff_cnt + 1'b1;
            end else begin
                case (eff_phase)
                    PH_PULSE: begin
                        if (i_tap_byte != '0) begin
                            pulse     = 1'b1;
                            pulse_len = LEN_W'(i_tap_byte);
                        end else begin
                            n_phase = PH_LEN0;
                        end
                    end
                    PH_LEN0: begin
                        n_long  = LEN_W'(i_tap_byte);
                        n_phase = PH_LEN1;
                    end
                    PH_LEN1: begin
                        n_long  = {i_tap_byte, i_tap_byte, eff_long[BYTE_W-1:0]};
                        n_long[LEN_W-1:2*BYTE_W] = '0;
                        n_phase = PH_LEN2;
                    end
                    default: begin
                        pulse     = 1'b1;
                        pulse_len = {i_tap_byte, eff_long[2*BYTE_W-1:0]};
                        n_phase   = PH_PULSE;
                    end
                endcase
            end
        end
    end

    // ones = n/2 + 1, never above n for n >= 1
    assign n_bits      = pulse_len[LEN_W-1:1];
    assign ones        = (n_bits >> 1) + 1'b1;
    assign o_job_valid = pulse && (n_bits != '0);
    assign o_job.ones  = ones;
    assign o_job.zeros = n_bits - ones;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len <= HDR_LEN_RST;
            r_hdr_cnt <= '0;
            r_phase   <= PH_PULSE;
            r_long    <= '0;
        end else begin
            r_hdr_len <= n_hdr_len;
            r_hdr_cnt <= n_hdr_cnt;
            r_phase   <= n_phase;
            r_long    <= n_long;
        end
    end

endmodule

[hw/rtl/tpb_job_queue.sv]
module tpb_job_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  tpb_pkg::t_job i_wr_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tpb_pkg::t_job o_head
);
    import tpb_pkg::*;

    localparam int PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(JQ_DEPTH + 1);

    t_job              r_mem [JQ_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full  = (r_count == CNT_QW'(JQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_wr   = i_wr_valid && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PTR_W'(JQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PTR_W'(JQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/tpb_back.sv]
module tpb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_avail,
    input  tpb_pkg::t_job    i_job,
    output logic             o_job_pop,
    input  logic             i_out_full,
    output logic             o_wr_valid,
    output tpb_pkg::t_result o_wr_data
);
    import tpb_pkg::*;

    t_bstate           r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_zeros, n_zeros;
    t_word             r_shift, n_shift;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_pend_valid, n_pend_valid;
    t_word             r_pend_word, n_pend_word;
    logic [REP_W-1:0]  r_pend_rep, n_pend_rep;

    logic              v;
    logic [FILL_W:0]   room;
    logic              is_run;
    logic [FILL_W:0]   k;
    logic [FILL_W:0]   sum;
    t_word             ins;
    t_word             sh;
    logic              e_valid;
    t_word             e_word;
    logic [REP_W-1:0]  e_rep;
    logic [FILL_W-1:0] st_fill;
    logic [CNT_W-1:0]  st_cnt;
    logic              phase_end;
    logic              step_en;
    logic              job_done;
    logic              merge;
    logic              load;

    // one packer step: top up a partial word, or send a run of full words and start a word with the rest
    always_comb begin
        v      = (r_state == B_ONES);
        room   = (FILL_W+1)'(WORD_BITS) - {1'b0, r_fill};
        is_run = (r_fill == '0) && (r_cnt >= CNT_W'(WORD_BITS));
        if (is_run) begin
            k = {1'b0, r_cnt[WB_LOG-1:0]};
        end else if (r_cnt < CNT_W'(room)) begin
            k = r_cnt[FILL_W:0];
        end else begin
            k = room;
        end
        ins = v ? ~({WORD_BITS{1'b1}} << k) : '0;
        sh  = (r_shift << k) | ins;
        sum = {1'b0, r_fill} + k;

        e_valid = 1'b0;
        e_word  = sh;
        e_rep   = REP_W'(1);
        if (is_run) begin
            e_valid = 1'b1;
            e_word  = v ? '1 : '0;
            e_rep   = REP_W'(r_cnt >> WB_LOG);
            st_fill = k[FILL_W-1:0];
            st_cnt  = '0;
        end else begin
            st_cnt = r_cnt - CNT_W'(k);
            if (sum == (FILL_W+1)'(WORD_BITS)) begin
                e_valid = 1'b1;
                st_fill = '0;
            end else begin
                st_fill = sum[FILL_W-1:0];
            end
        end
        phase_end = (st_cnt == '0);
    end

    assign step_en  = ((r_state == B_ONES) || (r_state == B_ZEROS)) && !i_out_full;
    assign job_done = step_en && phase_end && ((r_state == B_ZEROS) || (r_zeros == '0));
    assign merge    = r_pend_valid && e_valid && (e_word == r_pend_word);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_zeros      = r_zeros;
        n_shift      = r_shift;
        n_fill       = r_fill;
        n_pend_valid = r_pend_valid;
        n_pend_word  = r_pend_word;
        n_pend_rep   = r_pend_rep;
        o_wr_valid   = 1'b0;
        o_wr_data    = '0;
        load         = 1'b0;

        case (r_state)
            B_IDLE: begin
                load = 1'b1;
            end
            B_ONES, B_ZEROS: begin
                if (step_en) begin
                    n_shift = sh;
                    n_fill  = st_fill;
                    n_cnt   = st_cnt;
                    if (merge) begin
                        n_pend_rep = r_pend_rep + e_rep;
                    end else if (e_valid) begin
                        if (r_pend_valid) begin
                            o_wr_valid = 1'b1;
                            o_wr_data  = '{OUT_W'(r_pend_word), r_pend_rep, 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_word  = e_word;
                        n_pend_rep   = e_rep;
                    end
                    if (job_done) begin
                        if (e_valid && !merge && r_pend_valid) begin
                            n_state = B_FLUSH;
                        end else begin
                            if (e_valid && !r_pend_valid) begin
                                o_wr_valid = 1'b1;
                                o_wr_data  = '{OUT_W'(e_word), e_rep, 1'b1};
                            end else if (r_pend_valid) begin
                                o_wr_valid = 1'b1;
                                o_wr_data  = '{OUT_W'(r_pend_word), n_pend_rep, 1'b1};
                            end
                            n_pend_valid = 1'b0;
                            load         = 1'b1;
                        end
                    end else if (phase_end) begin
                        n_state = B_ZEROS;
                        n_cnt   = r_zeros;
                    end
                end
            end
            default: begin
                if (!i_out_full) begin
                    o_wr_valid   = 1'b1;
                    o_wr_data    = '{OUT_W'(r_pend_word), r_pend_rep, 1'b1};
                    n_pend_valid = 1'b0;
                    load         = 1'b1;
                end
            end
        endcase

        o_job_pop = load && i_job_avail;
        if (load) begin
            if (i_job_avail) begin
                n_state = B_ONES;
                n_cnt   = i_job.ones;
                n_zeros = i_job.zeros;
            end else begin
                n_state = B_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_zeros     <= n_zeros;
        r_pend_word <= n_pend_word;
        r_pend_rep  <= n_pend_rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_shift      <= '0;
            r_fill       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_shift      <= n_shift;
            r_fill       <= n_fill;
            r_pend_valid <= n_pend_valid;
        end
    end

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> !r_pend_valid)
        else $error("pending result held while idle");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FLUSH) |-> r_pend_valid)
        else $error("flush without pending result");

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_valid |-> !i_out_full)
        else $error("result written into full queue");

    a_pop_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == B_ONES) && (r_cnt != '0))
        else $error("job loaded with empty ones phase");

endmodule

[hw/rtl/tpb_out_queue.sv]
module tpb_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    input  tpb_pkg::t_result i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output tpb_pkg::t_result o_head
);
    import tpb_pkg::*;

    localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(OQ_DEPTH + 1);

    t_result           r_mem [OQ_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full  = (r_count == CNT_QW'(OQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_wr   = i_wr_valid && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/tap_pulse_to_bitstream_top.sv]
// Header and length bytes are taken at one per cycle while the job queue is not full. A pulse
// byte becomes a job for the packer unit, which takes up to two steps per bit phase and one more
// when two results leave at once; the front goes on taking bytes while the packer works.
// A two-entry job queue and a four-entry result queue let front and packer stall independently.
// Reset (i_rst_n low, synchronous): header_len back to 20, parser and packer cleared,
// both queues empty.
module tap_pulse_to_bitstream_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tpb_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  logic [tpb_pkg::BYTE_W-1:0] i_tap_byte,
    input  logic                       i_start_of_file,
    output logic                       empty,
    input  logic                       pop,
    output logic [tpb_pkg::OUT_W-1:0]  o_packed_word,
    output logic [tpb_pkg::REP_W-1:0]  o_repeat_count,
    output logic                       o_last
);
    import tpb_pkg::*;

    logic    job_wr_valid;
    t_job    job_wr;
    logic    jq_full;
    logic    jq_empty;
    t_job    jq_head;
    logic    job_pop;
    logic    res_wr_valid;
    t_result res_wr;
    logic    oq_full;
    t_result oq_head;

    tpb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_push          (push),
        .i_tap_byte      (i_tap_byte),
        .i_start_of_file (i_start_of_file),
        .i_jq_full       (jq_full),
        .o_job_valid     (job_wr_valid),
        .o_job           (job_wr)
    );

    tpb_job_queue u_job_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (job_wr_valid),
        .i_wr_data  (job_wr),
        .o_full     (jq_full),
        .i_pop      (job_pop),
        .o_empty    (jq_empty),
        .o_head     (jq_head)
    );

    tpb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!jq_empty),
        .i_job       (jq_head),
        .o_job_pop   (job_pop),
        .i_out_full  (oq_full),
        .o_wr_valid  (res_wr_valid),
        .o_wr_data   (res_wr)
    );

    tpb_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (res_wr_valid),
        .i_wr_data  (res_wr),
        .o_full     (oq_full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (oq_head)
    );

    assign full           = jq_full;
    assign o_packed_word  = oq_head.word;
    assign o_repeat_count = oq_head.rep;
    assign o_last         = oq_head.last;

endmodule

[tb/tpb_stream_checker.sv]
module tpb_stream_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tpb_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [tpb_pkg::BYTE_W-1:0] i_tap_byte,
    input  logic                       i_start_of_file,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [tpb_pkg::OUT_W-1:0]  i_packed_word,
    input  logic [tpb_pkg::REP_W-1:0]  i_repeat_count,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpb_pkg::*;

    localparam int MAX_RUNS = 4;

    // mirror of the block state
    logic [BYTE_W-1:0] hdr_len;
    logic [BYTE_W-1:0] hdr_cnt;
    t_phase            phase;
    logic [LEN_W-1:0]  long_len;
    t_word             pack_word;
    int unsigned       pack_fill;

    // words produced by the current byte, equal neighbours merged
    t_word             run_word [MAX_RUNS];
    int unsigned       run_rep  [MAX_RUNS];
    int                run_n;

    t_result           expected_words [$];
    int                fails;
    int                checked;

    function automatic void add_word(t_word w, int unsigned rep);
        if (run_n > 0 && run_word[run_n-1] == w) begin
            run_rep[run_n-1] += rep;
        end else if (run_n < MAX_RUNS) begin
            run_word[run_n] = w;
            run_rep[run_n]  = rep;
            run_n++;
        end
    endfunction

    function automatic void pack_bits(bit v, int unsigned count);
        int unsigned            whole;
        int unsigned            room;
        int unsigned            k;
        logic [2*WORD_BITS-1:0] ins;
        logic [2*WORD_BITS-1:0] wide;
        t_word                  fill_word;
        fill_word = v ? '1 : '0;
        while (count > 0) begin
            if (pack_fill == 0 && count >= WORD_BITS) begin
                whole = count / WORD_BITS;
                add_word(fill_word, whole);
                count -= whole * WORD_BITS;
            end else begin
                room = WORD_BITS - pack_fill;
                k    = (count < room) ? count : room;
                ins  = '0;
                if (v) begin
                    ins = 1;
                    ins = (ins << k) - 1;
                end
                wide       = ({{WORD_BITS{1'b0}}, pack_word} << k) | ins;
                pack_word  = wide[WORD_BITS-1:0];
                pack_fill += k;
                count     -= k;
                if (pack_fill >= WORD_BITS) begin
                    add_word(pack_word, 1);
                    pack_fill = 0;
                end
            end
        end
    endfunction

    function automatic void expand_pulse(int unsigned len);
        int unsigned nbits;
        int unsigned ones;
        nbits = len / 2;
        if (nbits == 0)
            return;
        ones = nbits / 2 + 1;
        if (ones > nbits)
            ones = nbits;
        pack_bits(1'b1, ones);
        pack_bits(1'b0, nbits - ones);
    endfunction

    function automatic void predict_tap_byte(logic [BYTE_W-1:0] b, logic sof);
        t_result r;
        run_n = 0;
        if (sof) begin
            hdr_cnt  = '0;
            phase    = PH_PULSE;
            long_len = '0;
        end
        if (hdr_cnt < hdr_len) begin
            hdr_cnt++;
            return;
        end
        case (phase)
            PH_PULSE: begin
                if (b != 0)
                    expand_pulse(b);
                else
                    phase = PH_LEN0;
            end
            PH_LEN0: begin
                long_len = LEN_W'(b);
                phase    = PH_LEN1;
            end
            PH_LEN1: begin
                long_len = long_len | (LEN_W'(b) << 8);
                phase    = PH_LEN2;
            end
            default: begin
                long_len = long_len | (LEN_W'(b) << 16);
                phase    = PH_PULSE;
                expand_pulse(long_len);
            end
        endcase
        for (int k = 0; k < run_n; k++) begin
            r.word = OUT_W'(run_word[k]);
            r.rep  = REP_W'(run_rep[k]);
            r.last = (k == run_n - 1);
            expected_words.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            hdr_len   = HDR_LEN_RST;
            hdr_cnt   = '0;
            phase     = PH_PULSE;
            long_len  = '0;
            pack_word = '0;
            pack_fill = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we)
                hdr_len = i_cfg_wdata;
            if (i_push && !i_full)
                predict_tap_byte(i_tap_byte, i_start_of_file);
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word %h rep %0d last %0b", $time,
                             i_packed_word, i_repeat_count, i_last);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (i_packed_word !== want.word) begin
                        fails++;
                        $display("%0t: packed_word expected %h, got %h", $time,
                                 want.word, i_packed_word);
                    end
                    if (i_repeat_count !== want.rep) begin
                        fails++;
                        $display("%0t: repeat_count expected %0d, got %0d", $time,
                                 want.rep, i_repeat_count);
                    end
                    if (i_last !== want.last) begin
                        fails++;
                        $display("%0t: last expected %0b, got %0b", $time,
                                 want.last, i_last);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
        o_checked    <= checked;
    end

endmodule

[tb/tap_pulse_to_bitstream_top_tb.sv]
module tap_pulse_to_bitstream_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpb_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYC  = 20;
    localparam int RAND_ITEMS  = 140;
    localparam int N_PHASES    = 4;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_wdata;
    logic              push;
    logic              full;
    logic [BYTE_W-1:0] tap_byte;
    logic              sof;
    logic              empty;
    logic              pop;
    logic [OUT_W-1:0]  packed_word;
    logic [REP_W-1:0]  repeat_count;
    logic              res_last;

    int fail_count;
    int pending;
    int checked;

    int cycles;
    int bytes_sent;
    int rand_items;
    int cur_hdr;
    int pop_hold;
    bit quiet;

    tap_pulse_to_bitstream_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .push            (push),
        .full            (full),
        .i_tap_byte      (tap_byte),
        .i_start_of_file (sof),
        .empty           (empty),
        .pop             (pop),
        .o_packed_word   (packed_word),
        .o_repeat_count  (repeat_count),
        .o_last          (res_last)
    );

    tpb_stream_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_push          (push),
        .i_full          (full),
        .i_tap_byte      (tap_byte),
        .i_start_of_file (sof),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_packed_word   (packed_word),
        .i_repeat_count  (repeat_count),
        .i_last          (res_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycles, pending);
            $display("[tap_pulse_to_bitstream_top] ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return LEN_W'($urandom_range(0, 400));
        if (r < 85)
            return LEN_W'($urandom_range(0, 16'hFFFF));
        if (r < 95)
            return LEN_W'($urandom);
        return '1;
    endfunction

    always @(negedge clk) begin
        if (quiet) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
            pop_hold = pick_gap();
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_byte(logic [BYTE_W-1:0] b, logic first);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push     <= 1'b1;
        tap_byte <= b;
        sof      <= first;
        do @(posedge clk); while (full);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_header_len(int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= BYTE_W'(v);
        cur_hdr    = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_len_seq(logic [LEN_W-1:0] len, logic first);
        send_byte('0, first);
        send_byte(len[7:0], 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[23:16], 1'b0);
    endtask

    // one file: header, then pulses and long lengths; some files end mid long length
    task automatic send_file(int body_len);
        int n;
        int r;
        bit first;
        first = 1'b1;
        for (int i = 0; i < cur_hdr; i++) begin
            send_byte(BYTE_W'($urandom), first);
            first = 1'b0;
        end
        n = 0;
        while (n < body_len) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_byte(BYTE_W'($urandom_range(1, 255)), first);
                n++;
            end else if (r < 85) begin
                send_len_seq(pick_length(), first);
                n += 4;
            end else if (r < 92) begin
                send_byte('0, first);
                send_byte(BYTE_W'($urandom), 1'b0);
                n += 2;
                break;
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)), first);
                n++;
            end
            first = 1'b0;
        end
        rand_items += n;
    endtask

    initial begin : stimulus
        int hdr_plan [N_PHASES];
        int quota;
        int body;
        int start;
        logic [BYTE_W-1:0] hb;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        push      = 1'b0;
        tap_byte  = '0;
        sof       = 1'b0;
        pop       = 1'b0;
        quiet     = 1'b0;
        cur_hdr   = HDR_LEN_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset header length; header bytes carry both byte extremes
        for (int i = 0; i < cur_hdr; i++) begin
            hb = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : BYTE_W'($urandom);
            send_byte(hb, i == 0);
        end
        send_byte(8'h01, 1'b0);          // halves to no bits
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_len_seq(24'h000000, 1'b0);
        send_len_seq(24'h000001, 1'b0);
        send_len_seq(24'hFFFFFF, 1'b0);
        settle();

        // no header; start of file cuts a long length short
        set_header_len(0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h41, 1'b1);
        send_len_seq(24'h000100, 1'b0);
        settle();

        hdr_plan = '{0, 1, $urandom_range(2, 12), $urandom_range(0, 6)};
        quota = RAND_ITEMS / N_PHASES + 1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_header_len(hdr_plan[ph]);
            quiet = (ph == 2);
            start = rand_items;
            body  = 0;
            while (body < quota) begin
                if (cur_hdr > 40)
                    send_file(quota - body);
                else
                    send_file($urandom_range(1, 20));
                body = rand_items - start;
            end
            settle();
            quiet = 1'b0;
        end

        $display("Sent %0d tape bytes (%0d random body bytes), checked %0d result words",
                 bytes_sent, rand_items, checked);
        $display("Header lengths 0, 1, 20 and small random; long lengths up to 24'hFFFFFF");
        if (fail_count == 0) begin
            $display("[tap_pulse_to_bitstream_top] OK");
        end else begin
            $display("[tap_pulse_to_bitstream_top] ERROR");
        end
        $finish;
    end

endmodule

[tap_pulse_to_bitstream_top.f]
hw/rtl/tpb_pkg.sv
hw/rtl/tpb_front.sv
hw/rtl/tpb_job_queue.sv
hw/rtl/tpb_back.sv
hw/rtl/tpb_out_queue.sv
hw/rtl/tap_pulse_to_bitstream_top.sv
tb/tpb_stream_checker.sv
tb/tap_pulse_to_bitstream_top_tb.sv
